[rtl/core/rcml_pkg.sv]
package rcml_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int ADDR_BITS_DEF     = 48;

  localparam int SLOT_BITS   = 6;
  localparam int MERGE_BITS  = 7;
  localparam int STATUS_BITS = 3;
  localparam int SHIFT_BITS  = 5;
  localparam int PADDR_BITS  = 3;
  localparam int PDATA_BITS  = 32;

  localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_MIN   = 5'd12;
  localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_MAX   = 5'd30;
  localparam logic [SHIFT_BITS-1:0] PAGE_SHIFT_RESET = 5'd12;

  localparam logic REG_PAGE_SHIFT = 1'b0;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_FLUSH  = 1'b1;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_HIT      = 3'd0,
    ST_INSERTED = 3'd1,
    ST_FULL     = 3'd2,
    ST_FLUSHED  = 3'd3,
    ST_RANGE    = 3'd4
  } status_t;

endpackage

[rtl/core/rcml_req_if.sv]
interface rcml_req_if #(
  parameter int ADDR_BITS = rcml_pkg::ADDR_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic [ADDR_BITS-1:0] req_start;
  logic [ADDR_BITS-1:0] req_length;

  modport source (output valid, req_type, req_start, req_length, input ready);
  modport sink   (input valid, req_type, req_start, req_length, output ready);
endinterface

[rtl/core/rcml_rsp_if.sv]
interface rcml_rsp_if #(
  parameter int ADDR_BITS = rcml_pkg::ADDR_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [rcml_pkg::STATUS_BITS-1:0]  status;
  logic [ADDR_BITS-1:0]              region_start;
  logic [ADDR_BITS:0]                region_length;
  logic [rcml_pkg::SLOT_BITS-1:0]    entry_slot;
  logic [rcml_pkg::MERGE_BITS-1:0]   merged_count;

  modport source (output valid, status, region_start, region_length, entry_slot,
                  merged_count, input ready);
  modport sink   (input valid, status, region_start, region_length, entry_slot,
                  merged_count, output ready);
endinterface

[rtl/core/rcml_table.sv]
module rcml_table #(
  parameter int TABLE_ENTRIES = rcml_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = rcml_pkg::ADDR_BITS_DEF,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IW-1:0]        waddr,
  input  logic [ADDR_BITS-1:0] wstart,
  input  logic [ADDR_BITS:0]   wlen,
  input  logic [IW-1:0]        raddr,
  output logic [ADDR_BITS-1:0] rstart,
  output logic [ADDR_BITS:0]   rlen
);

  logic [ADDR_BITS-1:0] mem_start [TABLE_ENTRIES];
  logic [ADDR_BITS:0]   mem_len   [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_len[waddr]   <= wlen;
    end
    rstart <= mem_start[raddr];
    rlen   <= mem_len[raddr];
  end

endmodule

[rtl/core/rcml_cfg.sv]
module rcml_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcml_pkg::PADDR_BITS-1:0] paddr,
  input  logic [rcml_pkg::PDATA_BITS-1:0] pwdata,
  output logic [rcml_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready,
  output logic [rcml_pkg::SHIFT_BITS-1:0] page_shift
);

  logic sel_shift;

  assign sel_shift = (paddr[2] == rcml_pkg::REG_PAGE_SHIFT);
  assign pready    = 1'b1;
  assign prdata    = sel_shift ?
                     {{(rcml_pkg::PDATA_BITS-rcml_pkg::SHIFT_BITS){1'b0}}, page_shift} :
                     '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_shift <= rcml_pkg::PAGE_SHIFT_RESET;
    end else if (psel && penable && pwrite && sel_shift) begin
      page_shift <= pwdata[rcml_pkg::SHIFT_BITS-1:0];
    end
  end

endmodule

[rtl/core/region_cache_merge_lookup_unit.sv]
// flush or range error goes straight to S_EMIT; a hit passes S_PRED, S_PCHK and S_EMIT
// insert: S_PRED, S_PCHK, S_WALK/S_WCHK per pass, S_FULL, S_FREE slot search, S_EMIT
// one pass over the table per absorbed following region plus a final one, one table read port
// one transaction at a time: a new request is accepted only in S_IDLE
// synchronous reset empties the table, page_shift resets to 12
module region_cache_merge_lookup_unit #(
  parameter int TABLE_ENTRIES = rcml_pkg::TABLE_ENTRIES_DEF,
  parameter int ADDR_BITS     = rcml_pkg::ADDR_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  rcml_req_if.sink                        req,
  rcml_rsp_if.source                      rsp,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rcml_pkg::PADDR_BITS-1:0] paddr,
  input  logic [rcml_pkg::PDATA_BITS-1:0] pwdata,
  output logic [rcml_pkg::PDATA_BITS-1:0] prdata,
  output logic                            pready
);

  localparam int A  = ADDR_BITS;
  localparam int N  = TABLE_ENTRIES;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N+1);

  typedef enum logic [2:0] {
    S_IDLE, S_PRED, S_PCHK, S_WALK, S_WCHK, S_FULL, S_FREE, S_EMIT
  } state_t;

  state_t state;

  logic [rcml_pkg::SHIFT_BITS-1:0] page_shift;
  logic [rcml_pkg::SHIFT_BITS-1:0] shift_eff;

  logic [N-1:0]  slot_valid;
  logic [N-1:0]  absorbed;
  logic [CW-1:0] used_count;
  logic [CW-1:0] merged;
  logic [CW-1:0] cnt;
  logic          rd_live;
  logic [IW-1:0] rd_idx;

  logic [A-1:0] rs_r;
  logic [A:0]   end_r;
  logic [A-1:0] start_r;
  logic         pf;
  logic [IW-1:0] p_idx;
  logic [A-1:0] p_s;
  logic [A:0]   p_l;
  logic         have_thr;
  logic [A-1:0] thr;
  logic         nf;
  logic [IW-1:0] n_idx;
  logic [A-1:0] n_s;
  logic [A:0]   n_l;

  rcml_pkg::status_t res_status;
  logic [A-1:0]  res_start;
  logic [A:0]    res_len;
  logic [IW-1:0] res_slot;
  logic [CW-1:0] res_merged;

  logic          out_valid;
  logic [A-1:0]  rd_start;
  logic [A:0]    rd_len;
  logic [A:0]    req_end;
  logic [A+1:0]  p_end;
  logic [A+1:0]  n_end;
  logic [A:0]    page_mask;
  logic [A:0]    end_round;
  logic          we;
  logic [A:0]    wlen;

  rcml_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .page_shift
  );

  rcml_table #(.TABLE_ENTRIES(N), .ADDR_BITS(A)) u_table (
    .clk,
    .we,
    .waddr  (cnt[IW-1:0]),
    .wstart (start_r),
    .wlen,
    .raddr  (cnt[IW-1:0]),
    .rstart (rd_start),
    .rlen   (rd_len)
  );

  always_comb begin
    if (page_shift < rcml_pkg::PAGE_SHIFT_MIN) begin
      shift_eff = rcml_pkg::PAGE_SHIFT_MIN;
    end else if (page_shift > rcml_pkg::PAGE_SHIFT_MAX) begin
      shift_eff = rcml_pkg::PAGE_SHIFT_MAX;
    end else begin
      shift_eff = page_shift;
    end
  end

  assign req_end   = {1'b0, req.req_start} + {1'b0, req.req_length};
  assign p_end     = {2'b0, p_s} + {1'b0, p_l};
  assign n_end     = {2'b0, n_s} + {1'b0, n_l};
  assign page_mask = ((A+1)'(1) << shift_eff) - (A+1)'(1);
  assign end_round = (end_r + page_mask) & ~page_mask;
  assign we        = (state == S_FREE) && !slot_valid[cnt[IW-1:0]];
  assign wlen      = end_r - {1'b0, start_r};
  assign req.ready = (state == S_IDLE);

  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      absorbed   <= '0;
      used_count <= '0;
      merged     <= '0;
      cnt        <= '0;
      rd_live    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            rs_r     <= req.req_start;
            end_r    <= req_end;
            start_r  <= req.req_start;
            absorbed <= '0;
            merged   <= '0;
            pf       <= 1'b0;
            cnt      <= '0;
            rd_live  <= 1'b0;
            res_start  <= '0;
            res_len    <= '0;
            res_slot   <= '0;
            res_merged <= '0;
            if (req.req_type == rcml_pkg::REQ_FLUSH) begin
              slot_valid <= '0;
              used_count <= '0;
              res_status <= rcml_pkg::ST_FLUSHED;
              state      <= S_EMIT;
            end else if (req_end[A] && (req_end[A-1:0] != '0)) begin
              res_status <= rcml_pkg::ST_RANGE;
              state      <= S_EMIT;
            end else begin
              state <= S_PRED;
            end
          end
        end
        S_PRED: begin
          if (cnt != CW'(N)) begin
            cnt     <= cnt + 1'b1;
            rd_live <= 1'b1;
            rd_idx  <= cnt[IW-1:0];
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live && slot_valid[rd_idx] && (rd_start <= rs_r) &&
              (!pf || (rd_start > p_s))) begin
            pf    <= 1'b1;
            p_idx <= rd_idx;
            p_s   <= rd_start;
            p_l   <= rd_len;
          end
          if ((cnt == CW'(N)) && !rd_live) begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          cnt      <= '0;
          rd_live  <= 1'b0;
          nf       <= 1'b0;
          have_thr <= pf;
          thr      <= p_s;
          if (pf && (p_end >= {1'b0, end_r})) begin
            res_status <= rcml_pkg::ST_HIT;
            res_start  <= p_s;
            res_len    <= p_l;
            res_slot   <= p_idx;
            state      <= S_EMIT;
          end else begin
            if (pf && ({2'b0, rs_r} <= p_end)) begin
              start_r         <= p_s;
              absorbed[p_idx] <= 1'b1;
              merged          <= CW'(1);
            end
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (cnt != CW'(N)) begin
            cnt     <= cnt + 1'b1;
            rd_live <= 1'b1;
            rd_idx  <= cnt[IW-1:0];
          end else begin
            rd_live <= 1'b0;
          end
          if (rd_live && slot_valid[rd_idx] && !absorbed[rd_idx] &&
              (!have_thr || (rd_start > thr)) && (!nf || (rd_start < n_s))) begin
            nf    <= 1'b1;
            n_idx <= rd_idx;
            n_s   <= rd_start;
            n_l   <= rd_len;
          end
          if ((cnt == CW'(N)) && !rd_live) begin
            state <= S_WCHK;
          end
        end
        S_WCHK: begin
          if (!nf || ({1'b0, n_s} > end_r)) begin
            state <= S_FULL;
          end else begin
            if (n_end > {1'b0, end_r}) begin
              end_r <= n_end[A:0];
            end
            absorbed[n_idx] <= 1'b1;
            merged          <= merged + 1'b1;
            thr             <= n_s;
            have_thr        <= 1'b1;
            nf              <= 1'b0;
            cnt             <= '0;
            rd_live         <= 1'b0;
            state           <= S_WALK;
          end
        end
        S_FULL: begin
          if ((merged == '0) && (used_count >= CW'(N))) begin
            res_status <= rcml_pkg::ST_FULL;
            state      <= S_EMIT;
          end else begin
            slot_valid <= slot_valid & ~absorbed;
            used_count <= used_count - merged;
            start_r    <= start_r & ~page_mask[A-1:0];
            end_r      <= end_round;
            cnt        <= '0;
            state      <= S_FREE;
          end
        end
        S_FREE: begin
          if (!slot_valid[cnt[IW-1:0]]) begin
            slot_valid[cnt[IW-1:0]] <= 1'b1;
            used_count <= used_count + 1'b1;
            res_status <= rcml_pkg::ST_INSERTED;
            res_start  <= start_r;
            res_len    <= wlen;
            res_slot   <= cnt[IW-1:0];
            res_merged <= merged;
            state      <= S_EMIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid         <= 1'b1;
            rsp.status        <= res_status;
            rsp.region_start  <= res_start;
            rsp.region_length <= res_len;
            rsp.entry_slot    <= rcml_pkg::SLOT_BITS'(res_slot);
            rsp.merged_count  <= rcml_pkg::MERGE_BITS'(res_merged);
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_used_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == used_count)
    else $error("used count differs from valid slots");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_count <= CW'(N))
    else $error("used count above table depth");

  a_merged_matches_absorbed: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> ($countones(absorbed) == merged))
    else $error("merged count differs from absorbed slots");

  a_free_found: assert property (@(posedge clk) disable iff (rst)
    (state == S_FREE) |-> (cnt < CW'(N)))
    else $error("free slot search ran past the table");

endmodule
